>>> design/diipad_pkg.sv
// Shared types and constants for the dual IIR phase/amplitude detector.
package diipad_pkg;

   localparam int THRESH_WIDTH = 23;
   localparam int Y_WIDTH      = 24;
   localparam int STATUS_WIDTH = 3;
   localparam int IDX_WIDTH    = 5;

   localparam logic [2:0] ST_NONE    = 3'd0;
   localparam logic [2:0] ST_RISE    = 3'd1;
   localparam logic [2:0] ST_FALL    = 3'd2;
   localparam logic [2:0] ST_PEAK    = 3'd3;
   localparam logic [2:0] ST_TROUGH  = 3'd4;

   localparam logic [2:0] SUPPRESS_DONE = 3'd5;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_COEF   = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_ROUND,
      S_DETECT,
      S_OUT
   } state_type;

   // control from sequencer to datapath
   typedef struct packed {
      logic clear_acc;
      logic mac_en;
      logic sub;
      logic phase_sel;
   } mac_ctrl_type;

endpackage

>>> design/diipad_mac.sv
// Shared multiply-accumulate with saturating 64-bit accumulator and Q.(COEF_WIDTH-4) rounding (Q.20 by default).
module diipad_mac #(
   parameter int COEF_WIDTH   = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  diipad_pkg::mac_ctrl_type   ctrl,
   input  logic                       use_x,
   input  logic signed [23:0]         operand,
   input  logic signed [COEF_WIDTH-1:0] coef,
   output logic signed [23:0]         result
);
   import diipad_pkg::*;

   localparam int FRAC = COEF_WIDTH - 4;
   localparam int PW   = 24 + COEF_WIDTH + 8;

   logic signed [PW-1:0] prod_ff, prod_in;
   logic                 pvalid_ff, pvalid_in;
   logic signed [63:0]   acc_ff, acc_in;
   logic signed [64:0]   sum;
   logic signed [64:0]   rnd;
   logic signed [64:0]   shifted;

   always_comb begin
      prod_in = PW'(operand) * PW'(coef);
      if (use_x) prod_in = prod_in <<< 8;
      if (ctrl.sub) prod_in = -prod_in;
      pvalid_in = ctrl.mac_en;
   end

   always_comb begin
      sum = 65'(acc_ff) + 65'(prod_ff);
      acc_in = acc_ff;
      if (ctrl.clear_acc) acc_in = '0;
      else if (pvalid_ff) begin
         if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) acc_in = 64'sh7FFF_FFFF_FFFF_FFFF;
         else if (sum < -65'sh0_8000_0000_0000_0000) acc_in = 64'sh8000_0000_0000_0000;
         else acc_in = sum[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         pvalid_ff <= pvalid_in;
         acc_ff    <= acc_in;
      end
      prod_ff <= prod_in;
   end

   always_comb begin
      rnd     = 65'(acc_ff) + (65'sd1 <<< (FRAC - 1));
      shifted = rnd >>> FRAC;
      if (shifted > 65'sd8388607) result = 24'sd8388607;
      else if (shifted < -65'sd8388608) result = -24'sd8388608;
      else result = shifted[23:0];
   end

   logic unused;
   assign unused = ctrl.phase_sel;
endmodule

>>> design/diipad_detect.sv
// Amplitude peak tracking and phase event detection.
module diipad_detect (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic [22:0]         threshold,
   input  logic signed [23:0]  pc,
   input  logic signed [23:0]  p1,
   input  logic signed [23:0]  p2,
   input  logic signed [23:0]  ac,
   input  logic signed [23:0]  a1,
   input  logic signed [23:0]  a2,
   output logic [2:0]          status,
   output logic [22:0]         peak
);
   import diipad_pkg::*;

   logic signed [24:0] tp_ff, tp_in;
   logic [2:0]         sd_ff, sd_in;
   logic [2:0]         st_ff, st_in;
   logic signed [24:0] th, nth;
   logic [2:0]         sd_inc;

   always_comb begin
      th = 25'($signed({2'b00, threshold}));
      nth = -th;
      tp_in = tp_ff;
      if (a1 > a2 && a1 > ac && 25'(a1) > th) tp_in = 25'(a1);
      else if (a1 < a2 && a1 < ac && 25'(a1) < nth) begin
         tp_in = -25'(a1);
         if (tp_in > 25'sd8388607) tp_in = 25'sd8388607;
      end
      sd_inc = (sd_ff < SUPPRESS_DONE) ? sd_ff + 3'd1 : sd_ff;
      st_in = ST_NONE;
      if (sd_inc == SUPPRESS_DONE) begin
         priority if (p1 > p2 && p1 > pc && tp_in > th) st_in = ST_PEAK;
         else if (p1 < p2 && p1 < pc && tp_in > th) st_in = ST_TROUGH;
         else if (pc < 0 && p1 > 0) st_in = ST_FALL;
         else if (pc > 0 && p1 < 0) st_in = ST_RISE;
         else st_in = ST_NONE;
      end
      sd_in = (st_in != ST_NONE) ? 3'd0 : sd_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tp_ff <= '0;
         sd_ff <= '0;
         st_ff <= ST_NONE;
      end else if (en) begin
         tp_ff <= tp_in;
         sd_ff <= sd_in;
         st_ff <= st_in;
      end
   end

   assign status = st_ff;
   assign peak   = tp_ff[22:0];
endmodule

>>> design/dual_iir_phase_amplitude_detector_unit.sv
// Top level: coefficient/history memories, tap sequencer and stream ports.
// Samples are processed one at a time: a new sample is accepted only after the previous
// result has been taken, with the single shared MAC walking each tap of both bands through
// the registered-read memories, plus rounding, detect reads and output.
// Coefficient writes are accepted only while idle.
// Synchronous active-high reset clears control state; histories and coefficients read as zero via valid bits.
module dual_iir_phase_amplitude_detector_unit #(
   parameter int ORDER        = 4,
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: sample, coef_index, coef_value, zero fill
   input  logic [((SAMPLE_WIDTH+5+COEF_WIDTH+7)/8)*8-1:0] req_tdata,
   // tuser: req_type
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: status [2:0], peak_amplitude [25:3], zero fill
   output logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import diipad_pkg::*;

   localparam int TAPS  = ORDER + 1;
   localparam int HIST  = (TAPS < 3) ? 3 : TAPS;
   localparam int NCOEF = 4 * TAPS;
   localparam int CW    = $clog2(NCOEF);
   localparam int HW    = $clog2(HIST);
   localparam int TW    = $clog2(2 * TAPS + 1);
   localparam int DW    = ((SAMPLE_WIDTH + 5 + COEF_WIDTH + 7) / 8) * 8;

   logic signed [SAMPLE_WIDTH-1:0] in_sample;
   logic [4:0]                     in_idx;
   logic signed [COEF_WIDTH-1:0]   in_coef;
   assign in_sample = req_tdata[SAMPLE_WIDTH-1:0];
   assign in_idx    = req_tdata[SAMPLE_WIDTH+4:SAMPLE_WIDTH];
   assign in_coef   = req_tdata[SAMPLE_WIDTH+5+COEF_WIDTH-1:SAMPLE_WIDTH+5];

   logic unused_pad;
   assign unused_pad = ^req_tdata[DW-1:SAMPLE_WIDTH+5+COEF_WIDTH];

   // config
   logic [22:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) thr_ff <= '0;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         thr_ff <= csr_pwdata[22:0];
   end
   assign csr_prdata = {9'd0, thr_ff};
   assign csr_pready = 1'b1;

   // memories
   logic signed [COEF_WIDTH-1:0] coef_mem [NCOEF];
   logic [NCOEF-1:0]             coef_v_ff;
   logic signed [COEF_WIDTH-1:0] coef_rd_ff;
   logic                         coef_rv_ff;
   logic signed [23:0]           hist_mem [3*HIST];
   logic [3*HIST-1:0]            hist_v_ff;
   logic signed [23:0]           hist_rd_ff;
   logic                         hist_rv_ff;

   state_type   st_ff, st_in;
   logic [TW-1:0] tap_ff, tap_in;
   logic        band_ff, band_in;
   logic [HW-1:0] pos_ff, pos_in;
   logic [2:0]  dcnt_ff, dcnt_in;
   logic signed [23:0] pc_ff, ac_ff, p1_ff, p2_ff, a1_ff, a2_ff;
   logic        rv_ff;
   logic        pend_ff;
   logic [2:0]  stat_ff;
   logic [22:0] pk_ff;

   logic accept;
   assign accept = req_tvalid && req_tready;
   assign req_tready = (st_ff == S_IDLE) && !rv_ff && !pend_ff;

   // tap sequence: even steps b-term with x, odd steps a-term with y (tap>=1)
   logic [HW:0]  tap_i;
   logic         is_a;
   logic [HW-1:0] k;
   logic [CW-1:0] caddr;
   logic [$clog2(3*HIST)-1:0] haddr;
   logic         mac_issue;
   logic         use_x_ff, issue_ff, sub_ff;
   logic         write_pos_x, write_pc, write_ac;

   always_comb begin
      tap_i = (HW+1)'(tap_ff >> 1);
      is_a  = tap_ff[0];
      k = (pos_ff >= HW'(tap_i)) ? pos_ff - HW'(tap_i) : HW'(pos_ff + HW'(HIST) - HW'(tap_i));
      caddr = CW'((band_ff ? 2 : 0) * TAPS + (is_a ? TAPS : 0)) + CW'(tap_i);
      haddr = is_a ? ($clog2(3*HIST))'((band_ff ? 2 : 1) * HIST) + ($clog2(3*HIST))'(k)
                   : ($clog2(3*HIST))'(k);
      if (st_ff == S_DETECT) begin
         priority case (dcnt_ff)
            3'd0: haddr = ($clog2(3*HIST))'(HIST) + ($clog2(3*HIST))'(k);
            3'd1: haddr = ($clog2(3*HIST))'(HIST) + ($clog2(3*HIST))'(
                            (k == '0) ? HW'(HIST - 1) : k - HW'(1));
            3'd2: haddr = ($clog2(3*HIST))'(2*HIST) + ($clog2(3*HIST))'(k);
            default: haddr = ($clog2(3*HIST))'(2*HIST) + ($clog2(3*HIST))'(
                            (k == '0) ? HW'(HIST - 1) : k - HW'(1));
         endcase
      end
      mac_issue = (st_ff == S_MAC) && !(is_a && tap_i == '0);
   end

   mac_ctrl_type mctl;
   logic signed [23:0] mac_res;
   logic signed [23:0] mac_op;
   assign mac_op = hist_rv_ff ? hist_rd_ff : 24'sd0;
   assign mctl.clear_acc = accept || write_pc;
   assign mctl.mac_en    = issue_ff;
   assign mctl.sub       = sub_ff;
   assign mctl.phase_sel = band_ff;

   diipad_mac #(.COEF_WIDTH(COEF_WIDTH)) u_mac (
      .clock(clock), .reset(reset), .ctrl(mctl), .use_x(use_x_ff),
      .operand(mac_op), .coef(coef_rv_ff ? coef_rd_ff : '0), .result(mac_res)
   );

   // sequencer
   always_comb begin
      st_in = st_ff; tap_in = tap_ff; band_in = band_ff; pos_in = pos_ff; dcnt_in = dcnt_ff;
      write_pos_x = 1'b0; write_pc = 1'b0; write_ac = 1'b0;
      unique case (st_ff)
         S_IDLE: if (accept && req_tuser == REQ_SAMPLE) begin
            st_in = S_MAC; tap_in = '0; band_in = 1'b0;
            pos_in = (pos_ff == HW'(HIST-1)) ? '0 : pos_ff + HW'(1);
            write_pos_x = 1'b1;
         end
         S_MAC: begin
            if (tap_ff == TW'(2*TAPS-1)) begin st_in = S_ROUND; dcnt_in = '0; end
            else tap_in = tap_ff + TW'(1);
         end
         S_ROUND: begin
            if (dcnt_ff == 3'd2) begin
               if (!band_ff) begin
                  write_pc = 1'b1; band_in = 1'b1; tap_in = '0; st_in = S_MAC;
               end else begin
                  // tap 1 points k at the previous slot for the detect reads
                  write_ac = 1'b1; st_in = S_DETECT; dcnt_in = '0; tap_in = TW'(2);
               end
            end else dcnt_in = dcnt_ff + 3'd1;
         end
         S_DETECT: begin
            if (dcnt_ff == 3'd4) st_in = S_OUT;
            else dcnt_in = dcnt_ff + 3'd1;
         end
         S_OUT: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; tap_ff <= '0; band_ff <= 1'b0;
         pos_ff <= HW'(HIST-1); dcnt_ff <= '0;
         coef_v_ff <= '0; hist_v_ff <= '0;
         issue_ff <= 1'b0;
      end else begin
         st_ff <= st_in; tap_ff <= tap_in; band_ff <= band_in;
         pos_ff <= pos_in; dcnt_ff <= dcnt_in;
         issue_ff <= mac_issue;
         if (accept && req_tuser == REQ_COEF && 6'(in_idx) < 6'(NCOEF))
            coef_v_ff[CW'(in_idx)] <= 1'b1;
         if (write_pos_x) hist_v_ff[pos_in] <= 1'b1;
         if (write_pc) hist_v_ff[HIST + int'(pos_ff)] <= 1'b1;
         if (write_ac) hist_v_ff[2*HIST + int'(pos_ff)] <= 1'b1;
      end
      use_x_ff <= !is_a;
      sub_ff   <= is_a;
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (accept && req_tuser == REQ_COEF && 6'(in_idx) < 6'(NCOEF))
         coef_mem[CW'(in_idx)] <= in_coef;
      coef_rd_ff <= coef_mem[caddr];
      coef_rv_ff <= coef_v_ff[caddr];
   end

   always_ff @(posedge clock) begin
      if (write_pos_x) hist_mem[pos_in] <= 24'(in_sample);
      else if (write_pc) hist_mem[HIST + int'(pos_ff)] <= mac_res;
      else if (write_ac) hist_mem[2*HIST + int'(pos_ff)] <= mac_res;
      hist_rd_ff <= hist_mem[haddr];
      hist_rv_ff <= hist_v_ff[haddr];
   end

   // detect operand capture
   logic signed [23:0] hrd;
   assign hrd = hist_rv_ff ? hist_rd_ff : 24'sd0;
   always_ff @(posedge clock) begin
      if (write_pc) pc_ff <= mac_res;
      if (write_ac) ac_ff <= mac_res;
      if (st_ff == S_DETECT) begin
         priority case (dcnt_ff)
            3'd1: p1_ff <= hrd;
            3'd2: p2_ff <= hrd;
            3'd3: a1_ff <= hrd;
            3'd4: a2_ff <= hrd;
            default: ;
         endcase
      end
   end

   logic [2:0]  d_status;
   logic [22:0] d_peak;
   diipad_detect u_det (
      .clock(clock), .reset(reset), .en(st_ff == S_OUT), .threshold(thr_ff),
      .pc(pc_ff), .p1(p1_ff), .p2(p2_ff), .ac(ac_ff), .a1(a1_ff), .a2(a2_ff),
      .status(d_status), .peak(d_peak)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         pend_ff <= (st_ff == S_OUT);
         if (pend_ff) rv_ff <= 1'b1;
         else if (rsp_tready) rv_ff <= 1'b0;
      end
      if (pend_ff) begin stat_ff <= d_status; pk_ff <= d_peak; end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {6'd0, pk_ff, stat_ff};
endmodule
